// ===== rtl/drp_pkg.sv =====
// drp_pkg: shared types and constants for the DER record parser.
// No dependencies; imported by drp_core and der_record_parser.
package drp_pkg;

  localparam int unsigned MAX_LEN_BYTES = 4;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TAG        = 3'd1;
  localparam logic [2:0] ERR_LEN_FORM   = 3'd2;
  localparam logic [2:0] ERR_SEQ_SIZE   = 3'd3;
  localparam logic [2:0] ERR_CONT_SIZE  = 3'd4;
  localparam logic [2:0] ERR_EARLY_END  = 3'd5;
  localparam logic [2:0] ERR_TRAILING   = 3'd6;

  localparam logic [2:0] FLD_HEADER   = 3'd0;
  localparam logic [2:0] FLD_ID       = 3'd1;
  localparam logic [2:0] FLD_CREATED  = 3'd2;
  localparam logic [2:0] FLD_EXPIRY   = 3'd3;
  localparam logic [2:0] FLD_INTERVAL = 3'd4;
  localparam logic [2:0] FLD_NOTES    = 3'd5;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_UTF8     = 8'h0C;
  localparam logic [7:0] TAG_GENTIME  = 8'h18;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;

  typedef struct packed {
    logic        produce;
    logic [2:0]  field_id;
    logic        data_valid;
    logic [7:0]  content_byte;
    logic        field_end;
    logic [31:0] interval_value;
    logic        record_ok;
    logic [2:0]  error_code;
  } res_t;

endpackage

// ===== rtl/drp_core.sv =====
// drp_core: parse state and per-byte next-state/result logic.
// Depends on drp_pkg. Advances one byte when fire is high.
module drp_core import drp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        first,
  input  logic [7:0]  in_byte,
  input  logic [31:0] record_size,
  output res_t        res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_TAG, PH_LEN_FIRST, PH_LEN_MORE, PH_CONTENT
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  element_index, element_index_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] content_left, content_left_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] sequence_end, sequence_end_next;
  logic [31:0] buffer_size, buffer_size_next;
  logic [31:0] int_accum, int_accum_next;

  function automatic logic [7:0] expected_tag(input logic [2:0] idx);
    unique case (idx)
      FLD_HEADER:   expected_tag = TAG_SEQUENCE;
      FLD_ID:       expected_tag = TAG_UTF8;
      FLD_CREATED:  expected_tag = TAG_GENTIME;
      FLD_EXPIRY:   expected_tag = TAG_GENTIME;
      FLD_INTERVAL: expected_tag = TAG_INTEGER;
      default:      expected_tag = TAG_UTF8;
    endcase
  endfunction

  always_comb begin
    logic [31:0] pos_after;
    logic [31:0] len_val;
    logic [32:0] end_pos;
    logic        do_len;
    logic        do_finish;
    logic [2:0]  err;
    logic [6:0]  n;

    phase_next             = phase;
    element_index_next     = element_index;
    length_bytes_left_next = length_bytes_left;
    length_accum_next      = length_accum;
    content_left_next      = content_left;
    byte_position_next     = byte_position;
    sequence_end_next      = sequence_end;
    buffer_size_next       = buffer_size;
    int_accum_next         = int_accum;
    if (first) begin
      phase_next             = PH_TAG;
      element_index_next     = FLD_HEADER;
      length_bytes_left_next = 3'd0;
      length_accum_next      = 32'd0;
      content_left_next      = 32'd0;
      byte_position_next     = 32'd0;
      sequence_end_next      = 32'd0;
      buffer_size_next       = record_size;
      int_accum_next         = 32'd0;
    end

    res           = '0;
    res.field_id  = element_index_next;
    pos_after     = byte_position_next + 32'd1;
    len_val       = {25'd0, in_byte[6:0]};
    do_len        = 1'b0;
    do_finish     = 1'b0;
    err           = ERR_NONE;
    n             = in_byte[6:0];
    end_pos       = '0;

    if (phase_next != PH_IDLE) begin
      res.produce = 1'b1;
      if (byte_position_next >= buffer_size_next) begin
        res.error_code = ERR_EARLY_END;
        phase_next     = PH_IDLE;
      end else begin
        unique case (phase_next)
          PH_TAG: begin
            if (element_index_next > FLD_NOTES ||
                in_byte != expected_tag(element_index_next)) begin
              err = ERR_TAG;
            end else begin
              if (element_index_next == FLD_INTERVAL) int_accum_next = 32'd0;
              phase_next = PH_LEN_FIRST;
            end
          end
          PH_LEN_FIRST: begin
            if (!in_byte[7]) begin
              do_len = 1'b1;
            end else if (n == 7'd0 || n > 7'(MAX_LEN_BYTES)) begin
              err = ERR_LEN_FORM;
            end else begin
              length_bytes_left_next = n[2:0];
              length_accum_next      = 32'd0;
              phase_next             = PH_LEN_MORE;
            end
          end
          PH_LEN_MORE: begin
            length_accum_next      = {length_accum_next[23:0], in_byte};
            length_bytes_left_next = length_bytes_left_next - 3'd1;
            len_val                = length_accum_next;
            do_len                 = (length_bytes_left_next == 3'd0);
          end
          PH_CONTENT: begin
            if (element_index_next == FLD_INTERVAL) begin
              int_accum_next = {int_accum_next[23:0], in_byte};
            end else begin
              res.data_valid   = 1'b1;
              res.content_byte = in_byte;
            end
            content_left_next = content_left_next - 32'd1;
            do_finish         = (content_left_next == 32'd0);
          end
          default: begin
            phase_next  = PH_IDLE;
            res.produce = 1'b0;
          end
        endcase

        if (do_len) begin
          end_pos = {1'b0, pos_after} + {1'b0, len_val};
          if (element_index_next == FLD_HEADER) begin
            if (end_pos > {1'b0, buffer_size_next}) begin
              err = ERR_SEQ_SIZE;
            end else begin
              sequence_end_next  = end_pos[31:0];
              res.field_end      = 1'b1;
              element_index_next = FLD_ID;
              phase_next         = PH_TAG;
            end
          end else if (end_pos > {1'b0, buffer_size_next}) begin
            err = ERR_CONT_SIZE;
          end else begin
            content_left_next = len_val;
            if (len_val == 32'd0) do_finish = 1'b1;
            else phase_next = PH_CONTENT;
          end
        end

        if (do_finish) begin
          res.field_end = 1'b1;
          if (element_index_next == FLD_INTERVAL) res.interval_value = int_accum_next;
          if (element_index_next >= FLD_NOTES) begin
            if (pos_after != sequence_end_next) err = ERR_TRAILING;
            else res.record_ok = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            element_index_next = element_index_next + 3'd1;
            phase_next         = PH_TAG;
          end
        end

        if (res.produce) begin
          byte_position_next = pos_after;
          if (err == ERR_NONE && phase_next != PH_IDLE && pos_after == buffer_size_next)
            err = ERR_EARLY_END;
          if (err != ERR_NONE) phase_next = PH_IDLE;
          res.error_code = err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      element_index     <= 3'd0;
      length_bytes_left <= 3'd0;
      length_accum      <= 32'd0;
      content_left      <= 32'd0;
      byte_position     <= 32'd0;
      sequence_end      <= 32'd0;
      buffer_size       <= 32'd0;
      int_accum         <= 32'd0;
    end else if (fire) begin
      phase             <= phase_next;
      element_index     <= element_index_next;
      length_bytes_left <= length_bytes_left_next;
      length_accum      <= length_accum_next;
      content_left      <= content_left_next;
      byte_position     <= byte_position_next;
      sequence_end      <= sequence_end_next;
      buffer_size       <= buffer_size_next;
      int_accum         <= int_accum_next;
    end
  end

endmodule

// ===== rtl/der_record_parser.sv =====
// der_record_parser: streaming DER record checker, one byte per transaction.
// Each accepted byte is held in a register, then its result is registered at the output.
// One byte per cycle unless out_stall holds output; next parse state is combinational.
// Bytes ignored while idle produce no result transaction.
// Reset (rst, synchronous): clears both handshake registers and the parse state.
// Depends on drp_pkg and drp_core.
module der_record_parser import drp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               first,
  input  logic [7:0]         in_byte,
  input  logic [31:0]        record_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         field_id,
  output logic               data_valid,
  output logic [7:0]         content_byte,
  output logic               field_end,
  output logic signed [31:0] interval_value,
  output logic               record_ok,
  output logic [2:0]         error_code
);

  logic        in_q_valid;
  logic        first_q;
  logic [7:0]  byte_q;
  logic [31:0] size_q;
  logic        fire;
  res_t        res;

  assign fire     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !fire;

  drp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .first       (first_q),
    .in_byte     (byte_q),
    .record_size (size_q),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      first_q <= first;
      byte_q  <= in_byte;
      size_q  <= record_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res.produce;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      field_id       <= res.field_id;
      data_valid     <= res.data_valid;
      content_byte   <= res.content_byte;
      field_end      <= res.field_end;
      interval_value <= $signed(res.interval_value);
      record_ok      <= res.record_ok;
      error_code     <= res.error_code;
    end
  end

endmodule
